// ===== rtl/dvae_pkg.sv =====
// package for the vector add engine: beat types, codes and register addresses
package dvae_pkg;

   localparam int AddrWidth = 32;
   localparam int DataWidth = 32;
   localparam int RegAddrWidth = 16;
   localparam int CsrIndexWidth = 2;

   // request actions
   localparam logic [1:0] ActRegWrite = 2'd0;
   localparam logic [1:0] ActRegRead  = 2'd1;
   localparam logic [1:0] ActMemData  = 2'd2;

   // response kinds
   localparam logic [2:0] KindRegData = 3'd0;
   localparam logic [2:0] KindMemRead = 3'd1;
   localparam logic [2:0] KindMemWrite = 3'd2;
   localparam logic [2:0] KindDone    = 3'd3;
   localparam logic [2:0] KindAddrErr = 3'd4;

   // register map on the request channel
   localparam logic [RegAddrWidth-1:0] RegSrcA = 16'd1024;
   localparam logic [RegAddrWidth-1:0] RegSrcB = 16'd1025;
   localparam logic [RegAddrWidth-1:0] RegDst  = 16'd1026;
   localparam logic [RegAddrWidth-1:0] RegLen  = 16'd1027;
   localparam logic [RegAddrWidth-1:0] RegCtrl = 16'd1028;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrSrcA = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSrcB = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrDst  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrLen  = 2'd3;

   typedef struct packed {
      logic [1:0]              action;
      logic [RegAddrWidth-1:0] reg_addr;
      logic [DataWidth-1:0]    word;
   } req_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [AddrWidth-1:0] bus_addr;
      logic [DataWidth-1:0] bus_data;
      logic                 last;
   } rsp_type;

endpackage

// ===== rtl/dma_vector_add_engine.sv =====
// top level of the vector add engine: register file, job control and response queue
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | dvae_pkg::req_type (action, reg_addr, word)
//   rsp     | out       | rsp_valid/rsp_stall  | dvae_pkg::rsp_type (kind, bus_addr, bus_data, last)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// each request beat is decoded and executed in the cycle it is accepted; its responses
// land in a two-slot response queue and leave one per cycle while rsp_stall is low
// a beat with one response sustains one beat per cycle while rsp_stall is low; a finished
// element (write plus next read or done) holds off the next beat on the single response port
// reset clears registers, job state and the queue; no clearing pass is needed
// req_stall rises while the queue cannot take two more responses, so a stalled
// rsp side backs up onto req after at most one beat
module dma_vector_add_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dvae_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dvae_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [dvae_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [dvae_pkg::DataWidth-1:0]      csr_wdata
);

   // configuration registers
   logic [dvae_pkg::AddrWidth-1:0] src_a_ff, src_a_in;
   logic [dvae_pkg::AddrWidth-1:0] src_b_ff, src_b_in;
   logic [dvae_pkg::AddrWidth-1:0] dst_ff, dst_in;
   logic [dvae_pkg::DataWidth-1:0] len_ff, len_in;

   // job state
   logic                           busy_ff, busy_in;
   logic [dvae_pkg::DataWidth-1:0] index_ff, index_in;
   logic                           second_ff, second_in;
   logic [dvae_pkg::DataWidth-1:0] first_word_ff, first_word_in;

   // response queue: slot 0 is the head
   dvae_pkg::rsp_type slot0_ff, slot0_in;
   dvae_pkg::rsp_type slot1_ff, slot1_in;
   logic [1:0]        count_ff, count_in;

   logic                     req_accept;
   logic                     rsp_pop;
   logic [1:0]               n_rsp;
   dvae_pkg::rsp_type        res0;
   dvae_pkg::rsp_type        res1;
   logic [dvae_pkg::DataWidth-1:0] next_index;
   logic [dvae_pkg::DataWidth-1:0] sum;
   logic                     job_end;
   logic [dvae_pkg::DataWidth-1:0] reg_value;

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_data   = slot0_ff;
   assign rsp_pop    = rsp_valid && !rsp_stall;
   // room for two responses once this cycle's pop is done
   assign req_stall  = !((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_pop));
   assign req_accept = req_valid && !req_stall;

   assign next_index = index_ff + 32'd1;
   assign sum        = first_word_ff + req_data.word;
   assign job_end    = (next_index == '0) || (next_index >= len_ff);

   // register read mux
   always_comb begin
      case (req_data.reg_addr)
         dvae_pkg::RegSrcA: reg_value = src_a_ff;
         dvae_pkg::RegSrcB: reg_value = src_b_ff;
         dvae_pkg::RegDst:  reg_value = dst_ff;
         dvae_pkg::RegLen:  reg_value = len_ff;
         default:           reg_value = {{(dvae_pkg::DataWidth-1){1'b0}}, busy_ff};
      endcase
   end

   // request decode and job control
   always_comb begin
      src_a_in      = src_a_ff;
      src_b_in      = src_b_ff;
      dst_in        = dst_ff;
      len_in        = len_ff;
      busy_in       = busy_ff;
      index_in      = index_ff;
      second_in     = second_ff;
      first_word_in = first_word_ff;
      n_rsp         = 2'd0;
      res0          = '{kind: dvae_pkg::KindAddrErr, bus_addr: '0, bus_data: '0, last: 1'b1};
      res1          = '{kind: dvae_pkg::KindDone, bus_addr: '0, bus_data: '0, last: 1'b1};

      if (req_accept) begin
         case (req_data.action)
            dvae_pkg::ActRegWrite: begin
               if (req_data.reg_addr inside {[dvae_pkg::RegSrcA:dvae_pkg::RegLen]}) begin
                  case (req_data.reg_addr)
                     dvae_pkg::RegSrcA: src_a_in = req_data.word;
                     dvae_pkg::RegSrcB: src_b_in = req_data.word;
                     dvae_pkg::RegDst:  dst_in   = req_data.word;
                     default:           len_in   = req_data.word;
                  endcase
               end else if (req_data.reg_addr == dvae_pkg::RegCtrl) begin
                  // start: zero write or start while busy is dropped
                  if (req_data.word != '0 && !busy_ff) begin
                     n_rsp = 2'd1;
                     if (len_ff == '0) begin
                        res0.kind = dvae_pkg::KindDone;
                     end else begin
                        busy_in       = 1'b1;
                        index_in      = '0;
                        second_in     = 1'b0;
                        res0.kind     = dvae_pkg::KindMemRead;
                        res0.bus_addr = src_a_ff;
                     end
                  end
               end else begin
                  n_rsp         = 2'd1;
                  res0.bus_addr = {{(dvae_pkg::AddrWidth-dvae_pkg::RegAddrWidth){1'b0}},
                                   req_data.reg_addr};
               end
            end
            dvae_pkg::ActRegRead: begin
               n_rsp         = 2'd1;
               res0.bus_addr = {{(dvae_pkg::AddrWidth-dvae_pkg::RegAddrWidth){1'b0}},
                                req_data.reg_addr};
               if (req_data.reg_addr inside {[dvae_pkg::RegSrcA:dvae_pkg::RegCtrl]}) begin
                  res0.kind     = dvae_pkg::KindRegData;
                  res0.bus_data = reg_value;
               end
            end
            dvae_pkg::ActMemData: begin
               if (busy_ff) begin
                  if (!second_ff) begin
                     // first operand back, fetch the second
                     n_rsp         = 2'd1;
                     first_word_in = req_data.word;
                     second_in     = 1'b1;
                     res0.kind     = dvae_pkg::KindMemRead;
                     res0.bus_addr = src_b_ff + index_ff;
                  end else begin
                     // both operands in: write the sum, then next read or done
                     n_rsp         = 2'd2;
                     second_in     = 1'b0;
                     res0.kind     = dvae_pkg::KindMemWrite;
                     res0.bus_addr = dst_ff + index_ff;
                     res0.bus_data = sum;
                     res0.last     = 1'b0;
                     if (job_end) begin
                        busy_in  = 1'b0;
                        index_in = '0;
                     end else begin
                        index_in      = next_index;
                        res1.kind     = dvae_pkg::KindMemRead;
                        res1.bus_addr = src_a_ff + next_index;
                     end
                  end
               end
            end
            default: begin
               // unused action, dropped
            end
         endcase
      end

      // csr writes are for the user to make only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            dvae_pkg::CsrSrcA: src_a_in = csr_wdata;
            dvae_pkg::CsrSrcB: src_b_in = csr_wdata;
            dvae_pkg::CsrDst:  dst_in   = csr_wdata;
            dvae_pkg::CsrLen:  len_in   = csr_wdata;
            default:           len_in   = len_ff;
         endcase
      end
   end

   // response queue update
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (req_accept) begin
         // queue is empty after this cycle's pop
         slot0_in = res0;
         slot1_in = res1;
         count_in = n_rsp;
      end else if (rsp_pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_a_ff  <= '0;
         src_b_ff  <= '0;
         dst_ff    <= '0;
         len_ff    <= '0;
         busy_ff   <= 1'b0;
         index_ff  <= '0;
         second_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         src_a_ff  <= src_a_in;
         src_b_ff  <= src_b_in;
         dst_ff    <= dst_in;
         len_ff    <= len_in;
         busy_ff   <= busy_in;
         index_ff  <= index_in;
         second_ff <= second_in;
         count_ff  <= count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      first_word_ff <= first_word_in;
      slot0_ff      <= slot0_in;
      slot1_ff      <= slot1_in;
   end

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("response queue overflow");

   // idle job keeps its operand phase and index cleared
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (!second_ff && index_ff == '0))
      else $error("idle job state not cleared");

   // a beat that finishes an element leaves two responses behind
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && busy_ff && second_ff && req_data.action == dvae_pkg::ActMemData)
      |=> (count_ff == 2'd2 && !second_ff))
      else $error("element write lost its follow-up response");

   // busy only rises on an accepted start
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(req_accept))
      else $error("job started without a request beat");

endmodule
